// File: hdl/mtx_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 keystream XOR package
// Shared constants, types and the tempering function of the keystream cipher block.
// ----------------------------------------------------------------------------
package mtx_pkg;

  localparam int unsigned N = 624;
  localparam int unsigned M = 397;
  localparam int unsigned IdxW = 10;
  localparam logic [31:0] Matrix = 32'h9908_B0DF;
  localparam logic [31:0] InitMul = 32'd1812433253;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(N - 1);
  localparam logic [IdxW-1:0] MOff = IdxW'(M);
  localparam logic [IdxW-1:0] NMinusM = IdxW'(N - M);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TWIST_RD,
    ST_TWIST_WR,
    ST_DRAW_RD,
    ST_LOAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic seed_start;
    logic seed_step;
    logic twist_start;
    logic twist_rd;
    logic twist_wr;
    logic draw_rd;
    logic load_word;
    logic latch_in;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic seed_done;
    logic twist_done;
    logic need_twist;
    logic pos_zero;
  } status_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: hdl/mt19937_keystream_xor_top.sv
// A byte within the current word has its result valid in the cycle after acceptance.
// A byte that begins a new word first passes through a table read and a tempering state.
// Every 624 words the table is twisted first, with a read step and a write step per entry.
// A reseed runs the seeding recurrence ahead of that twist, with a multiply and a write step per entry.
// A new byte is taken only after the previous one has been delivered; a stalled output holds the FSM.
// Reset is asynchronous, active low; the seed register resets to 5489.
// ----------------------------------------------------------------------------
// MT19937 keystream XOR top level
// Byte stream cipher with a reseedable MT19937 keystream generator.
// ----------------------------------------------------------------------------
module mt19937_keystream_xor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // message_start
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast    // out_last
);

  logic [31:0] seed_q;
  mtx_pkg::cmd_t cmd;
  mtx_pkg::status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 32'd5489;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  mtx_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_start_i(s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .status_i(status)
  );

  mtx_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .seed_i(seed_q),
    .in_byte_i(s_axis_tdata), .in_last_i(s_axis_tlast),
    .out_byte_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );

endmodule

// File: hdl/mtx_datapath.sv
// ----------------------------------------------------------------------------
// MT19937 keystream XOR datapath
// State table memory, seeding and twist units, tempering and byte XOR.
// ----------------------------------------------------------------------------
module mtx_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtx_pkg::cmd_t      cmd_i,
  output mtx_pkg::status_t   status_o,
  input  logic [31:0]        seed_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  logic [31:0] mem [mtx_pkg::N];
  logic [31:0] rda_q, rdb_q;
  logic [mtx_pkg::IdxW-1:0] idx_q, idx_d, tidx_q;
  logic [mtx_pkg::IdxW-1:0] tidx_n, tidx_m;
  logic [31:0] prev_q, mul_q, word_q;
  logic [31:0] seed_v;
  logic seed_ph_q;
  logic hi_q, top_q;
  logic [1:0] pos_q;
  logic [7:0] byte_q;
  logic last_q;
  logic [31:0] twist_v, y;

  assign tidx_n = (tidx_q == mtx_pkg::LastIdx) ? '0 : tidx_q + 1'b1;
  assign tidx_m = (tidx_q >= mtx_pkg::NMinusM) ? tidx_q - mtx_pkg::NMinusM
                                               : tidx_q + mtx_pkg::MOff;
  assign seed_v = mul_q + 32'(tidx_q);
  // The upper bit of the current entry is carried over from the previous read.
  assign y = {hi_q, rda_q[30:0]};
  assign twist_v = rdb_q ^ (y >> 1) ^ (y[0] ? mtx_pkg::Matrix : 32'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_start) begin
      mem[0] <= seed_i;
    end else if (cmd_i.seed_step && seed_ph_q) begin
      mem[tidx_q] <= seed_v;
    end else if (cmd_i.twist_wr) begin
      mem[tidx_q] <= twist_v;
    end
    if (cmd_i.twist_rd || cmd_i.draw_rd) begin
      rda_q <= mem[cmd_i.draw_rd ? idx_q : tidx_n];
      rdb_q <= mem[tidx_m];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.seed_start) begin
      idx_d = mtx_pkg::IdxW'(mtx_pkg::N);
    end else if (cmd_i.twist_start) begin
      idx_d = '0;
    end else if (cmd_i.draw_rd) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= mtx_pkg::IdxW'(mtx_pkg::N);
      tidx_q    <= '0;
      seed_ph_q <= 1'b0;
      pos_q     <= '0;
      word_q    <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.seed_start) begin
        tidx_q    <= 10'd1;
        seed_ph_q <= 1'b0;
        pos_q     <= '0;
      end else if (cmd_i.seed_step) begin
        seed_ph_q <= ~seed_ph_q;
        if (seed_ph_q) begin
          tidx_q <= tidx_n;
        end
      end else if (cmd_i.twist_start) begin
        tidx_q <= '0;
      end else if (cmd_i.twist_wr) begin
        tidx_q <= tidx_n;
      end
      if (cmd_i.load_word) begin
        word_q <= mtx_pkg::temper(rda_q);
      end
      if (cmd_i.emit) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // The seed recurrence alternates a multiply phase and a write phase per entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_start) begin
      prev_q <= seed_i;
    end else if (cmd_i.seed_step && seed_ph_q) begin
      prev_q <= seed_v;
    end
    if (cmd_i.seed_step && !seed_ph_q) begin
      mul_q <= mtx_pkg::InitMul * (prev_q ^ (prev_q >> 30));
    end
    if (cmd_i.seed_start) begin
      top_q <= seed_i[31];
    end else if (cmd_i.twist_wr && (tidx_q == '0)) begin
      top_q <= twist_v[31];
    end
    if (cmd_i.twist_start) begin
      hi_q <= top_q;
    end else if (cmd_i.twist_wr) begin
      hi_q <= rda_q[31];
    end
    if (cmd_i.latch_in) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  assign status_o.seed_done  = (tidx_q == mtx_pkg::LastIdx) && seed_ph_q;
  assign status_o.twist_done = (tidx_q == mtx_pkg::LastIdx);
  assign status_o.need_twist = (idx_q >= mtx_pkg::IdxW'(mtx_pkg::N));
  assign status_o.pos_zero   = (pos_q == 2'd0);

  assign out_byte_o = byte_q ^ word_q[8*pos_q +: 8];
  assign out_last_o = last_q;

endmodule

// File: hdl/mtx_ctrl.sv
// ----------------------------------------------------------------------------
// MT19937 keystream XOR controller
// Sequences seeding, twisting, drawing and byte delivery.
// ----------------------------------------------------------------------------
module mtx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_start_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtx_pkg::cmd_t     cmd_o,
  input  mtx_pkg::status_t  status_i
);

  mtx_pkg::state_e state_q, state_d;
  logic seeded_q, seeded_d;
  logic acc;

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    seeded_d = seeded_q;
    unique case (state_q)
      mtx_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_start_i || !seeded_q) begin
            state_d  = mtx_pkg::ST_SEED;
            seeded_d = 1'b1;
          end else if (!status_i.pos_zero) begin
            state_d = mtx_pkg::ST_OUT;
          end else if (status_i.need_twist) begin
            state_d = mtx_pkg::ST_TWIST_RD;
          end else begin
            state_d = mtx_pkg::ST_DRAW_RD;
          end
        end
      end
      mtx_pkg::ST_SEED: begin
        if (status_i.seed_done) begin
          state_d = mtx_pkg::ST_TWIST_RD;
        end
      end
      mtx_pkg::ST_TWIST_RD: state_d = mtx_pkg::ST_TWIST_WR;
      mtx_pkg::ST_TWIST_WR: begin
        if (status_i.twist_done) begin
          state_d = mtx_pkg::ST_DRAW_RD;
        end else begin
          state_d = mtx_pkg::ST_TWIST_RD;
        end
      end
      mtx_pkg::ST_DRAW_RD: state_d = mtx_pkg::ST_LOAD;
      mtx_pkg::ST_LOAD: state_d = mtx_pkg::ST_OUT;
      mtx_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = mtx_pkg::ST_IDLE;
        end
      end
      default: state_d = mtx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == mtx_pkg::ST_IDLE);
    out_valid_o = (state_q == mtx_pkg::ST_OUT);
    unique case (state_q)
      mtx_pkg::ST_IDLE: begin
        cmd_o.latch_in = in_valid_i;
        cmd_o.seed_start = in_valid_i && (in_start_i || !seeded_q);
        cmd_o.twist_start = in_valid_i && !(in_start_i || !seeded_q) &&
                            status_i.pos_zero && status_i.need_twist;
      end
      mtx_pkg::ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        cmd_o.twist_start = status_i.seed_done;
      end
      mtx_pkg::ST_TWIST_RD: cmd_o.twist_rd = 1'b1;
      mtx_pkg::ST_TWIST_WR: cmd_o.twist_wr = 1'b1;
      mtx_pkg::ST_DRAW_RD: cmd_o.draw_rd = 1'b1;
      mtx_pkg::ST_LOAD: cmd_o.load_word = 1'b1;
      mtx_pkg::ST_OUT: cmd_o.emit = out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mtx_pkg::ST_IDLE;
      seeded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seeded_q <= seeded_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> state_q == mtx_pkg::ST_IDLE) else $error("accept while busy");
  a_seeded_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> seeded_q) else $error("seeded flag not set");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

endmodule
